### rtl/htb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htb_pkg
// shared types and codes of the huffman tree builder
// ----------------------------------------------------------------------------
package htb_pkg;
	localparam int OP_WIDTH   = 2;
	localparam int BYTE_WIDTH = 8;
	localparam int ID_WIDTH   = 10;
	localparam int OUT_COUNT_WIDTH = 32;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_COUNT  = 2'd1,
		OP_FINISH = 2'd2,
		OP_MERGE  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FIN_RD,
		ST_FIN_WR,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_SHIFT,
		ST_APPEND,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_COUNTING = 2'd0,
		PH_BUILDING = 2'd1,
		PH_DONE     = 2'd2
	} phase_t;

	// controller to datapath
	typedef struct packed {
		logic clr_start;   // start clear sweep / reset registers
		logic clr_step;    // one clear address
		logic cnt_byte;    // count accepted byte
		logic fin_start;   // bump end marker, start load sweep
		logic fin_rd;      // histogram read address advance
		logic fin_wr;      // load one entry into list
		logic scan_start;
		logic scan_step;
		logic scan_take;   // latch minimum and start shift
		logic shift_step;
		logic append;
		logic emit_root;
		logic out_take;
	} htb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic fin_last;
		logic scan_last;
		logic shift_last;
		logic len_zero;
		logic len_one;
		logic second;      // second minimum taken
	} htb_sts_t;
endpackage

### rtl/htb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htb_in_if / htb_out_if
// valid/ready channels of the huffman tree builder
// ----------------------------------------------------------------------------
interface htb_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] byte_value;
	modport source (output valid, op, byte_value, input ready);
	modport sink   (input valid, op, byte_value, output ready);
endinterface

interface htb_out_if;
	logic        valid;
	logic        ready;
	logic [9:0]  left_node;
	logic [9:0]  right_node;
	logic [9:0]  new_node;
	logic [31:0] new_count;
	logic        done_res;
	modport source (output valid, left_node, right_node, new_node, new_count, done_res,
		input ready);
	modport sink   (input valid, left_node, right_node, new_node, new_count, done_res,
		output ready);
endinterface

### rtl/huffman_tree_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_builder
// histogram, node list and stepwise huffman merge
// ----------------------------------------------------------------------------
// Byte counting takes one word a cycle while no clear, finish or merge is in
// progress. After reset, and after every clear word, the histogram is swept
// clear with the input held off. The finish word walks the histogram and loads
// its nonzero entries into the node list. Each merge word scans and compacts
// the node list twice on one list memory port before the result is
// registered; a merge word with one node left emits the root.
module huffman_tree_builder import htb_pkg::*; #(
	parameter int ALPHABET    = 257,
	parameter int COUNT_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	htb_in_if.sink    in_ch,
	htb_out_if.source out_ch
);
	htb_cmd_t cmd;
	htb_sts_t sts;
	logic     ov;

	// sequencer
	htb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_op(in_ch.op),
		.out_valid(ov), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	// memories and arithmetic
	htb_dp #(.ALPHABET(ALPHABET), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_byte(in_ch.byte_value),
		.cmd(cmd), .sts(sts), .out_valid(ov),
		.out_left(out_ch.left_node), .out_right(out_ch.right_node),
		.out_new(out_ch.new_node), .out_count(out_ch.new_count),
		.out_done(out_ch.done_res)
	);
	assign out_ch.valid = ov;
endmodule

### rtl/htb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htb_ctrl
// sequencer for clear, count, list load and merge steps
// ----------------------------------------------------------------------------
module htb_ctrl import htb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic [1:0] in_op,
	input  logic     out_valid,
	input  logic     out_ready,
	input  htb_sts_t sts,
	output htb_cmd_t cmd
);
	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic   acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			phase_q <= PH_COUNTING;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	assign acc = in_valid && in_ready;

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		cmd      = '0;
		in_ready = 1'b0;
		cmd.out_take = out_valid && out_ready;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				// a merge needs the output register free
				in_ready = !(in_op == OP_MERGE && out_valid && !out_ready);
				if (acc) begin
					case (op_t'(in_op))
						OP_CLEAR: begin
							cmd.clr_start = 1'b1;
							phase_d = PH_COUNTING;
							state_d = ST_CLEAR;
						end
						OP_COUNT: cmd.cnt_byte = (phase_q == PH_COUNTING);
						OP_FINISH: if (phase_q == PH_COUNTING) begin
							cmd.fin_start = 1'b1;
							phase_d = PH_BUILDING;
							state_d = ST_FIN_RD;
						end
						OP_MERGE: if (phase_q != PH_COUNTING && !sts.len_zero) begin
							if (sts.len_one) begin
								cmd.emit_root = 1'b1;
								phase_d = PH_DONE;
							end else begin
								cmd.scan_start = 1'b1;
								state_d = ST_SCAN;
							end
						end
						default: ;
					endcase
				end
			end
			ST_FIN_RD: begin
				cmd.fin_rd = 1'b1;
				state_d = ST_FIN_WR;
			end
			ST_FIN_WR: begin
				cmd.fin_wr = 1'b1;
				if (sts.fin_last) state_d = ST_IDLE;
				else cmd.fin_rd = 1'b1;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) state_d = ST_SCAN_LAST;
			end
			ST_SCAN_LAST: begin
				cmd.scan_take = 1'b1;
				state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (sts.shift_last) begin
					if (sts.second) state_d = ST_APPEND;
					else begin
						cmd.scan_start = 1'b1;
						state_d = ST_SCAN;
					end
				end
			end
			ST_APPEND: begin
				cmd.append = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

### rtl/htb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htb_dp
// histogram and node list memories, minimum scan, shift and merge
// ----------------------------------------------------------------------------
module htb_dp import htb_pkg::*; #(
	parameter int ALPHABET    = 257,
	parameter int COUNT_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  htb_cmd_t   cmd,
	output htb_sts_t   sts,
	output logic       out_valid,
	output logic [ID_WIDTH-1:0] out_left,
	output logic [ID_WIDTH-1:0] out_right,
	output logic [ID_WIDTH-1:0] out_new,
	output logic [OUT_COUNT_WIDTH-1:0] out_count,
	output logic       out_done
);
	localparam int AW = $clog2(ALPHABET);
	localparam int LW = $clog2(ALPHABET + 1);
	localparam int NW = $clog2(2 * ALPHABET);
	localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
	localparam logic [AW-1:0] EOM = AW'(ALPHABET - 1);

	logic [COUNT_WIDTH-1:0] hist_mem [ALPHABET];
	logic [NW+COUNT_WIDTH-1:0] list_mem [ALPHABET];

	// histogram port: read registered, write one address
	logic [AW-1:0]  h_raddr, h_waddr;
	logic           h_we;
	logic [COUNT_WIDTH-1:0] h_wdata, h_rdata_q;
	// byte counting uses a registered read-modify-write with forwarding
	logic           cnt_s1;
	logic [AW-1:0]  cnt_addr_s1;
	logic [COUNT_WIDTH-1:0] cnt_old, cnt_inc;

	logic [AW:0]    clr_q;        // clear sweep address
	logic [AW:0]    frd_q;        // load read address
	logic [AW-1:0]  fwr_addr_q;   // address whose data is in h_rdata_q
	logic [LW-1:0]  len_q;
	logic [NW-1:0]  next_id_q;

	// list port
	logic [AW-1:0]  l_raddr, l_waddr;
	logic           l_we;
	logic [NW+COUNT_WIDTH-1:0] l_wdata, l_rdata_q;
	logic [AW:0]    scan_q;       // scan read index
	logic           scan_vld_q;
	logic [AW-1:0]  scan_pos_q;   // index of l_rdata_q
	logic [AW-1:0]  best_pos_q;
	logic [NW-1:0]  best_id_q;
	logic [COUNT_WIDTH-1:0] best_cnt_q;
	logic           second_q;
	logic [NW-1:0]  r_id_q;
	logic [COUNT_WIDTH-1:0] r_cnt_q;
	logic [AW:0]    sh_q;         // shift read index
	logic           sh_vld_q;
	logic [NW-1:0]  rdid;
	logic [COUNT_WIDTH-1:0] rdcnt, sum;
	logic [COUNT_WIDTH:0] sum_w;
	// minimum including the entry on the read port this cycle
	logic           scan_upd;
	logic [NW-1:0]  nb_id;
	logic [COUNT_WIDTH-1:0] nb_cnt;
	logic [AW-1:0]  nb_pos;
	// root read: entry zero is kept in a shadow register
	logic [NW-1:0] rdid_len0_id;
	logic [COUNT_WIDTH-1:0] rdid_len0_cnt;
	logic [NW-1:0] fwr_id;

	assign rdid  = l_rdata_q[NW+COUNT_WIDTH-1:COUNT_WIDTH];
	assign rdcnt = l_rdata_q[COUNT_WIDTH-1:0];

	assign scan_upd = scan_vld_q && (scan_pos_q == '0 || rdcnt < best_cnt_q);
	assign nb_id    = scan_upd ? rdid : best_id_q;
	assign nb_cnt   = scan_upd ? rdcnt : best_cnt_q;
	assign nb_pos   = scan_upd ? scan_pos_q : best_pos_q;

	// histogram control
	always_comb begin
		h_raddr = AW'(in_byte);
		if (cmd.fin_start) h_raddr = EOM;
		else if (cmd.fin_rd) h_raddr = frd_q[AW-1:0];
		h_we = 1'b0;
		h_waddr = cnt_addr_s1;
		h_wdata = cnt_inc;
		if (cmd.clr_step) begin
			h_we = 1'b1; h_waddr = clr_q[AW-1:0]; h_wdata = '0;
		end else if (cnt_s1) begin
			h_we = 1'b1;
		end
	end
	assign cnt_old = h_rdata_q;
	assign cnt_inc = (cnt_old == CMAX) ? cnt_old : cnt_old + 1'b1;

	always_ff @(posedge clk) begin
		if (h_we) hist_mem[h_waddr] <= h_wdata;
		if (h_we && h_waddr == h_raddr) h_rdata_q <= h_wdata;
		else h_rdata_q <= hist_mem[h_raddr];
	end

	logic byte_ok;
	always_comb begin
		byte_ok = 1'b0;
		if (ALPHABET - 1 > 255) byte_ok = 1'b1;
		else byte_ok = ({1'b0, in_byte} < 9'(ALPHABET - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= 1'b0;
			cnt_addr_s1 <= '0;
			clr_q <= '0;
			len_q <= '0;
			next_id_q <= NW'(ALPHABET);
			out_valid <= 1'b0;
			scan_vld_q <= 1'b0;
			sh_vld_q <= 1'b0;
			second_q <= 1'b0;
		end else begin
			cnt_s1 <= (cmd.cnt_byte && byte_ok) || cmd.fin_start;
			cnt_addr_s1 <= h_raddr;
			if (cmd.clr_start) begin
				clr_q <= '0; len_q <= '0; next_id_q <= NW'(ALPHABET);
			end else if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.fin_start) begin
				frd_q <= '0; len_q <= '0;
			end else if (cmd.fin_rd) frd_q <= frd_q + 1'b1;
			if (cmd.fin_rd) fwr_addr_q <= frd_q[AW-1:0];
			if (cmd.fin_wr && h_rdata_q != '0) len_q <= len_q + 1'b1;
			if (cmd.out_take) out_valid <= 1'b0;
			if (cmd.emit_root) begin
				out_valid <= 1'b1; out_done <= 1'b1;
				out_left <= '0; out_right <= '0;
				out_new <= ID_WIDTH'(rdid_len0_id);
				out_count <= OUT_COUNT_WIDTH'(rdid_len0_cnt);
			end
			// scan: stream list entries and track first minimum
			scan_vld_q <= cmd.scan_step;
			if (cmd.scan_start) begin
				scan_q <= '0;
				best_cnt_q <= CMAX; best_pos_q <= '0; best_id_q <= '0;
				if (!second_q && cmd.scan_start && !cmd.shift_step) second_q <= 1'b0;
			end else if (cmd.scan_step) scan_q <= scan_q + 1'b1;
			if (cmd.scan_step) scan_pos_q <= scan_q[AW-1:0];
			if (scan_upd) begin
				best_cnt_q <= rdcnt; best_id_q <= rdid; best_pos_q <= scan_pos_q;
			end
			if (cmd.scan_take) begin
				sh_q <= {1'b0, nb_pos} + 1'b1;
				if (!second_q) begin
					r_id_q <= nb_id; r_cnt_q <= nb_cnt;
				end
			end else if (cmd.shift_step) sh_q <= sh_q + 1'b1;
			sh_vld_q <= cmd.shift_step && !sts.shift_last;
			if (cmd.shift_step && sts.shift_last) begin
				len_q <= len_q - 1'b1;
				second_q <= !second_q;
			end
			if (cmd.append) begin
				len_q <= len_q + 1'b1;
				next_id_q <= next_id_q + 1'b1;
				out_valid <= 1'b1; out_done <= 1'b0;
				out_left <= ID_WIDTH'(best_id_q);
				out_right <= ID_WIDTH'(r_id_q);
				out_new <= ID_WIDTH'(next_id_q);
				out_count <= OUT_COUNT_WIDTH'(sum);
			end
		end
	end

	assign sum_w = {1'b0, r_cnt_q} + {1'b0, best_cnt_q};
	assign sum   = sum_w[COUNT_WIDTH] ? CMAX : sum_w[COUNT_WIDTH-1:0];

	always_ff @(posedge clk) begin
		if (l_we && l_waddr == '0) begin
			rdid_len0_id  <= l_wdata[NW+COUNT_WIDTH-1:COUNT_WIDTH];
			rdid_len0_cnt <= l_wdata[COUNT_WIDTH-1:0];
		end
	end

	assign fwr_id = NW'(fwr_addr_q);

	// list port control; shift reads sh_q while writing sh_q-2
	always_comb begin
		l_raddr = scan_q[AW-1:0];
		if (cmd.shift_step) l_raddr = sh_q[AW-1:0];
		l_we = 1'b0;
		l_waddr = AW'(len_q);
		l_wdata = {fwr_id, h_rdata_q};
		if (cmd.fin_wr && h_rdata_q != '0) l_we = 1'b1;
		if (sh_vld_q) begin
			l_we = 1'b1; l_waddr = AW'(sh_q - 2'd2); l_wdata = l_rdata_q;
		end
		if (cmd.append) begin
			l_we = 1'b1; l_waddr = AW'(len_q); l_wdata = {next_id_q, sum};
		end
	end

	always_ff @(posedge clk) begin
		if (l_we) list_mem[l_waddr] <= l_wdata;
		l_rdata_q <= list_mem[l_raddr];
	end

	assign sts.clr_last   = (clr_q == (AW+1)'(ALPHABET - 1));
	assign sts.fin_last   = (fwr_addr_q == EOM);
	assign sts.scan_last  = (scan_q == (AW+1)'(len_q) - 1'b1);
	assign sts.shift_last = (sh_q >= (AW+1)'(len_q));
	assign sts.len_zero   = (len_q == '0);
	assign sts.len_one    = (len_q == LW'(1));
	assign sts.second     = second_q;
endmodule

### rtl/htb_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htb_chk
// port checks for the huffman tree builder
// ----------------------------------------------------------------------------
module htb_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [9:0] left_node,
	input logic [9:0] right_node,
	input logic done_res
);
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_root: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> left_node == '0 && right_node == '0)
		else $error("root has children");
	a_reset: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result after reset");
endmodule

bind huffman_tree_builder htb_chk u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.left_node(out_ch.left_node), .right_node(out_ch.right_node),
	.done_res(out_ch.done_res)
);
